@@ rtl/core/fsss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fsss_pkg
// Shared types, constants and the tuple fold for the flow signature seen set.
// ----------------------------------------------------------------------------
package fsss_pkg;

	localparam int unsigned FSSS_SET_ENTRIES = 16384;
	localparam int unsigned FSSS_PROBE_LIMIT = 16;

	localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
	localparam int unsigned MIX_SHIFT = 33;

	typedef logic [31:0] addr_t;
	typedef logic [15:0] port_t;
	typedef logic [7:0]  proto_t;
	typedef logic [63:0] sig_t;

	typedef struct packed {
		addr_t  addr_low;
		addr_t  addr_high;
		port_t  port_first;
		port_t  port_second;
		proto_t protocol;
	} tuple_t;

	// Folds the 5-tuple into 64 bits before mixing.
	function automatic sig_t fold_tuple(input tuple_t t);
		fold_tuple = {t.addr_low, 32'h0} ^ {32'h0, t.addr_high} ^ {t.port_first, 48'h0}
			^ {16'h0, t.port_second, 32'h0} ^ {56'h0, t.protocol};
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/flow_signature_seen_set_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flow_signature_seen_set_core
// Set of 64-bit flow signatures in one synchronous RAM, searched by linear
// probing; reports whether each flow tuple was seen before.
// ----------------------------------------------------------------------------
// Flow: the hash finalizer runs on one shared 32x32 multiplier; the start slot
//   is the masked signature for a power-of-two SET_ENTRIES, else it is reduced
//   by a byte fold, reciprocal quotient and remainder step. Once it is loaded,
//   the RAM read port probes one slot a cycle, up to PROBE_LIMIT slots (at most
//   the whole table), each judged the cycle after its read.
// Throughput: one item at a time; a new item is taken only once the result of
//   the last one is registered, which waits for a free output register.
// Reset: arst_n clears control; afterwards the RAM is swept to zero, one slot
//   per cycle, over all SET_ENTRIES slots while in_ready stays low.
// ----------------------------------------------------------------------------
module flow_signature_seen_set_core #(
	parameter int unsigned SET_ENTRIES = fsss_pkg::FSSS_SET_ENTRIES,
	parameter int unsigned PROBE_LIMIT = fsss_pkg::FSSS_PROBE_LIMIT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire fsss_pkg::addr_t  addr_low,
	input  wire fsss_pkg::addr_t  addr_high,
	input  wire fsss_pkg::port_t  port_first,
	input  wire fsss_pkg::port_t  port_second,
	input  wire fsss_pkg::proto_t protocol,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  is_new,
	output logic                  crowded
);
	import fsss_pkg::*;

	localparam int unsigned IDX_W = $clog2(SET_ENTRIES);
	// The probe run never covers more than the whole table.
	localparam int unsigned LIMIT_EFF = (PROBE_LIMIT > SET_ENTRIES) ? SET_ENTRIES : PROBE_LIMIT;
	localparam int unsigned CNT_W = $clog2(LIMIT_EFF + 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_PROBE = 3'd3;
	localparam logic [2:0] ST_HOLD  = 3'd4;

	// Signature RAM: one write port, one registered read port.
	sig_t mem [SET_ENTRIES];

	logic [2:0]       state_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic [IDX_W-1:0] addr_q;
	logic [CNT_W-1:0] issue_cnt_q;
	logic             rd_vld_s1;
	logic             rd_last_s1;
	logic [IDX_W-1:0] rd_addr_s1;
	sig_t             rd_data_s1;
	logic             res_new_q;
	logic             res_crowded_q;
	logic             out_valid_q;
	logic             is_new_q;
	logic             crowded_q;

	tuple_t           tuple;
	logic             in_acc;
	logic             hash_done;
	sig_t             hash_sig;
	logic [IDX_W-1:0] hash_slot;

	logic             issue;
	logic             slot_empty;
	logic             slot_match;
	logic             decided;
	logic             out_free;
	logic             res_new;
	logic             res_crowded;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	sig_t             wr_data;
	logic [IDX_W-1:0] addr_next;

	assign tuple = '{addr_low: addr_low, addr_high: addr_high, port_first: port_first,
		port_second: port_second, protocol: protocol};

	// An item is taken only when the control is idle; the output register
	// may still be holding the previous result.
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	fsss_hash #(
		.SET_ENTRIES(SET_ENTRIES)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_acc),
		.tuple (tuple),
		.done  (hash_done),
		.sig   (hash_sig),
		.slot  (hash_slot)
	);

	// Reads are issued back to back; each one is judged once the registered
	// read data returns. Once a slot decides, the read still in flight is
	// dropped. No write happens until the decision, and the next item cannot
	// read before the hash has run again, so no forwarding is needed.
	assign issue      = (state_q == ST_PROBE) && (issue_cnt_q != CNT_W'(LIMIT_EFF));
	assign slot_empty = (rd_data_s1 == '0);
	assign slot_match = (rd_data_s1 == hash_sig);
	assign decided    = (state_q == ST_PROBE) && rd_vld_s1
		&& (slot_empty || slot_match || rd_last_s1);
	assign res_new     = !slot_match;
	assign res_crowded = !slot_empty && !slot_match;

	assign out_free = !out_valid_q || out_ready;

	assign addr_next = (addr_q == IDX_W'(SET_ENTRIES - 1)) ? '0 : addr_q + IDX_W'(1);

	// The write port is shared by the clearing sweep and the insert.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_addr_s1;
		wr_data = hash_sig;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (decided && slot_empty) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue && !decided;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + IDX_W'(1);
					if (clr_addr_q == IDX_W'(SET_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (decided) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Probe addressing and result payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_HASH && hash_done) begin
			addr_q      <= hash_slot;
			issue_cnt_q <= '0;
		end else if (issue) begin
			addr_q      <= addr_next;
			issue_cnt_q <= issue_cnt_q + CNT_W'(1);
		end
		if (issue) begin
			rd_addr_s1 <= addr_q;
			rd_last_s1 <= (issue_cnt_q == CNT_W'(LIMIT_EFF - 1));
		end
		if (decided) begin
			res_new_q     <= res_new;
			res_crowded_q <= res_crowded;
		end
		if (decided && out_free) begin
			is_new_q  <= res_new;
			crowded_q <= res_crowded;
		end else if (state_q == ST_HOLD && out_free) begin
			is_new_q  <= res_new_q;
			crowded_q <= res_crowded_q;
		end
	end

	assign out_valid = out_valid_q;
	assign is_new    = is_new_q;
	assign crowded   = crowded_q;

endmodule
`default_nettype wire

@@ rtl/core/fsss_hash.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fsss_hash
// Multi-cycle signature unit: tuple fold, 64-bit finalizer on one shared
// 32x32 multiplier, zero fix-up and start slot (mask, or byte fold followed
// by a reciprocal multiply for other sizes).
// ----------------------------------------------------------------------------
module fsss_hash #(
	parameter int unsigned SET_ENTRIES = fsss_pkg::FSSS_SET_ENTRIES,
	localparam int unsigned IDX_W = $clog2(SET_ENTRIES)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire fsss_pkg::tuple_t tuple,
	output logic                  done,
	output fsss_pkg::sig_t        sig,
	output logic [IDX_W-1:0]      slot
);
	import fsss_pkg::*;

	localparam bit IS_POW2 = ((SET_ENTRIES & (SET_ENTRIES - 1)) == 0);

	localparam logic [31:0] MOD_N = 32'(SET_ENTRIES);
	// Quotient estimate scale; the estimate is short by at most one.
	localparam logic [31:0] RECIP = 32'((64'd1 << 31) / 64'(SET_ENTRIES));

	localparam logic [2:0] H_IDLE = 3'd0;
	localparam logic [2:0] H_MUL0 = 3'd1;
	localparam logic [2:0] H_MUL1 = 3'd2;
	localparam logic [2:0] H_MUL2 = 3'd3;
	localparam logic [2:0] H_FIX  = 3'd4;
	localparam logic [2:0] H_SUM  = 3'd5;
	localparam logic [2:0] H_QUOT = 3'd6;
	localparam logic [2:0] H_REM  = 3'd7;

	logic [2:0]       hst_q;
	logic             round_q;
	sig_t             v_q;
	logic [63:0]      p0_q;
	logic [31:0]      cross_q;
	sig_t             sig_q;
	logic [31:0]      y_q;
	logic [31:0]      q_q;
	logic             done_q;
	logic [IDX_W-1:0] slot_q;

	sig_t        folded;
	sig_t        v_init;
	logic [63:0] mul_c;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [31:0] hi_sum;
	sig_t        prod_full;
	sig_t        mixed;
	sig_t        fixed;
	logic [31:0]      fold_term [8];
	logic [31:0]      fold_sum;
	logic [63:0]      quot_prod;
	logic [63:0]      back_prod;
	logic [31:0]      rem_raw;
	logic [IDX_W-1:0] rem_next;

	assign folded = fold_tuple(tuple);
	assign v_init = folded ^ (folded >> MIX_SHIFT);

	// Low 64 bits of v * C from three partial products, one per cycle.
	assign mul_c  = round_q ? MIX_MUL_B : MIX_MUL_A;
	assign mul_a  = (hst_q == H_MUL1) ? v_q[63:32] : v_q[31:0];
	assign mul_b  = (hst_q == H_MUL2) ? mul_c[63:32] : mul_c[31:0];
	assign prod   = {32'h0, mul_a} * {32'h0, mul_b};
	assign hi_sum = p0_q[63:32] + cross_q + prod[31:0];
	assign prod_full = {hi_sum, p0_q[31:0]};
	assign mixed  = prod_full ^ (prod_full >> MIX_SHIFT);

	assign fixed  = (v_q == '0) ? 64'd1 : v_q;

	// Each signature byte is weighted by 2^(8i) mod SET_ENTRIES, which keeps the
	// congruent sum below 2040 * SET_ENTRIES (below 2^31 for SET_ENTRIES up to 2^20).
	for (genvar gi = 0; gi < 8; gi++) begin : g_fold
		localparam logic [31:0] BYTE_W = 32'((64'd1 << (8 * gi)) % 64'(SET_ENTRIES));
		assign fold_term[gi] = {24'h0, sig_q[8*gi +: 8]} * BYTE_W;
	end

	assign fold_sum  = fold_term[0] + fold_term[1] + fold_term[2] + fold_term[3]
		+ fold_term[4] + fold_term[5] + fold_term[6] + fold_term[7];
	assign quot_prod = {32'h0, y_q} * {32'h0, RECIP};
	assign back_prod = {32'h0, q_q} * {32'h0, MOD_N};
	assign rem_raw   = y_q - back_prod[31:0];
	assign rem_next  = (rem_raw >= MOD_N) ? IDX_W'(rem_raw - MOD_N) : rem_raw[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hst_q   <= H_IDLE;
			round_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (hst_q)
				H_IDLE: begin
					if (start) begin
						round_q <= 1'b0;
						hst_q   <= H_MUL0;
					end
				end
				H_MUL0: hst_q <= H_MUL1;
				H_MUL1: hst_q <= H_MUL2;
				H_MUL2: begin
					round_q <= 1'b1;
					hst_q   <= round_q ? H_FIX : H_MUL0;
				end
				H_FIX: begin
					if (IS_POW2) begin
						done_q <= 1'b1;
						hst_q  <= H_IDLE;
					end else begin
						hst_q <= H_SUM;
					end
				end
				H_SUM:  hst_q <= H_QUOT;
				H_QUOT: hst_q <= H_REM;
				H_REM: begin
					done_q <= 1'b1;
					hst_q  <= H_IDLE;
				end
				default: hst_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (hst_q)
			H_IDLE: begin
				if (start) begin
					v_q <= v_init;
				end
			end
			H_MUL0: p0_q <= prod;
			H_MUL1: cross_q <= prod[31:0];
			H_MUL2: v_q <= mixed;
			H_FIX: begin
				sig_q  <= fixed;
				slot_q <= fixed[IDX_W-1:0];
			end
			H_SUM:  y_q <= fold_sum;
			H_QUOT: q_q <= quot_prod[62:31];
			H_REM:  slot_q <= rem_next;
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign sig  = sig_q;
	assign slot = slot_q;

endmodule
`default_nettype wire

@@ rtl/core/fsss_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fsss_checker
// Port-level checks of the flow signature seen set, bound to the top level.
// ----------------------------------------------------------------------------
module fsss_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic is_new,
	input wire logic crowded
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_new) && $stable(crowded))
		else $error("result changed while stalled");

	// A crowded lookup never reports the flow as seen.
	a_crowded_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && crowded |-> is_new)
		else $error("crowded result without is_new");

	// One item at a time: taking an item closes the input.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still open after accept");

	// A new result only appears while an item is in work.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised while idle");

endmodule

bind flow_signature_seen_set_core fsss_checker u_fsss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.is_new   (is_new),
	.crowded  (crowded)
);
`default_nettype wire
